>>> rtl/i2c_master_register_access_core_macros.svh
// Assertion macros shared by the I2C register access core
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2cm_pkg.sv
// Shared types and constants for the I2C register access core
package i2cm_pkg;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd3;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       data_req;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       done_res;
        logic       failed;
    } t_out_word;

endpackage

>>> rtl/i2cm_step.sv
// Bus sequencer: state registers and per-tick next-state logic
`include "i2c_master_register_access_core_macros.svh"

module i2cm_step
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output t_out_word o_res
);

    typedef enum logic [4:0] {
        P_IDLE, P_ST_A, P_ST_B, P_TX_SETUP, P_TX_HIGH, P_TX_LOW,
        P_ACK_SETUP, P_ACK_HIGH, P_ACK_POLL, P_LOAD_REQ, P_LOAD_TAKE,
        P_RX_LOW, P_RX_HIGH, P_MA_SETUP, P_MA_HIGH, P_SP_A, P_SP_B
    } t_phase;

    typedef enum logic [2:0] {
        S_DEV, S_REG, S_RDEV, S_DATA, S_FAIL
    } t_stage;

    t_phase     r_phase, n_phase;
    t_stage     r_stage, n_stage;
    logic [7:0] r_tick, n_tick;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes, n_bytes;
    logic [7:0] r_poll, n_poll;
    logic       r_is_read, n_is_read;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_half, r_ato;

    logic       dly;
    logic [7:0] tick_inc;
    logic [3:0] bit_inc;
    logic [7:0] rx_byte;
    logic       acked;
    t_out_word  res_word;

    assign tick_inc = r_tick + 8'd1;
    assign dly      = ({1'b0, r_tick} + 9'd1) >= {1'b0, r_half};
    assign bit_inc  = r_bit + 4'd1;
    assign rx_byte  = (r_tick == 8'd0) ? {r_shift[6:0], i_word.sda_in} : r_shift;
    assign acked    = !i_word.sda_in;

    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        n_poll    = r_poll;
        n_is_read = r_is_read;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_scl     = r_scl;
        n_sda     = r_sda;
        res_word          = '0;
        res_word.scl      = r_scl;
        res_word.sda_out  = r_sda;

        case (r_phase)
            P_IDLE: begin
                if (i_word.op inside {OP_WRITE, OP_READ}) begin
                    n_is_read = (i_word.op == OP_READ);
                    n_dev     = i_word.dev_addr;
                    n_reg     = i_word.reg_addr;
                    n_bytes   = i_word.byte_count;
                    n_shift   = i_word.dev_addr;
                    n_stage   = S_DEV;
                    n_scl     = 1'b1;
                    n_sda     = 1'b1;
                    n_tick    = '0;
                    n_phase   = P_ST_A;
                end
            end
            P_ST_A: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_sda   = 1'b0;
                    n_phase = P_ST_B;
                end
            end
            P_ST_B: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_bit   = '0;
                    n_scl   = 1'b0;
                    n_sda   = r_shift[7];
                    n_phase = P_TX_SETUP;
                end
            end
            P_TX_SETUP: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b1;
                    n_phase = P_TX_HIGH;
                end
            end
            P_TX_HIGH: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b0;
                    n_phase = P_TX_LOW;
                end
            end
            P_TX_LOW: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_bit   = bit_inc;
                    n_shift = {r_shift[6:0], 1'b0};
                    if (bit_inc < 4'd8) begin
                        n_sda   = r_shift[6];
                        n_phase = P_TX_SETUP;
                    end else begin
                        n_sda   = 1'b1;
                        n_phase = P_ACK_SETUP;
                    end
                end
            end
            P_ACK_SETUP: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b1;
                    n_phase = P_ACK_HIGH;
                end
            end
            P_ACK_HIGH: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_poll  = '0;
                    n_phase = P_ACK_POLL;
                end
            end
            P_ACK_POLL: begin
                if (acked || (r_poll >= r_ato)) begin
                    n_scl  = 1'b0;
                    n_tick = '0;
                    case (r_stage)
                        S_DEV: begin
                            if (!acked) begin
                                n_stage = S_FAIL;
                                n_sda   = 1'b0;
                                n_phase = P_SP_A;
                            end else begin
                                n_stage = S_REG;
                                n_shift = r_reg;
                                n_bit   = '0;
                                n_sda   = r_reg[7];
                                n_phase = P_TX_SETUP;
                            end
                        end
                        S_REG: begin
                            if (r_is_read) begin
                                n_stage = S_RDEV;
                                n_shift = r_dev + 8'd1;
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                                n_phase = P_ST_A;
                            end else if (r_bytes == 8'd0) begin
                                n_sda   = 1'b0;
                                n_phase = P_SP_A;
                            end else begin
                                n_phase = P_LOAD_REQ;
                            end
                        end
                        S_RDEV: begin
                            if (r_bytes == 8'd0) begin
                                n_sda   = 1'b0;
                                n_phase = P_SP_A;
                            end else begin
                                n_bit   = '0;
                                n_sda   = 1'b1;
                                n_phase = P_RX_LOW;
                            end
                        end
                        default: begin
                            if (!acked) begin
                                n_stage = S_FAIL;
                                n_sda   = 1'b0;
                                n_phase = P_SP_A;
                            end else if (r_bytes == 8'd0) begin
                                n_sda   = 1'b0;
                                n_phase = P_SP_A;
                            end else begin
                                n_phase = P_LOAD_REQ;
                            end
                        end
                    endcase
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end
            P_LOAD_REQ: begin
                res_word.data_req = 1'b1;
                n_tick  = '0;
                n_phase = P_LOAD_TAKE;
            end
            P_LOAD_TAKE: begin
                n_shift = i_word.wr_data;
                n_bytes = r_bytes - 8'd1;
                n_stage = S_DATA;
                n_bit   = '0;
                n_scl   = 1'b0;
                n_sda   = i_word.wr_data[7];
                n_tick  = '0;
                n_phase = P_TX_SETUP;
            end
            P_RX_LOW: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b1;
                    n_phase = P_RX_HIGH;
                end
            end
            P_RX_HIGH: begin
                n_shift = rx_byte;
                n_tick  = dly ? '0 : tick_inc;
                if (dly) begin
                    n_bit = bit_inc;
                    n_scl = 1'b0;
                    if (bit_inc < 4'd8) begin
                        n_phase = P_RX_LOW;
                    end else begin
                        res_word.rd_valid = 1'b1;
                        res_word.rd_data  = rx_byte;
                        res_word.rd_last  = (r_bytes == 8'd1);
                        n_bytes = r_bytes - 8'd1;
                        n_sda   = (r_bytes == 8'd1);
                        n_phase = P_MA_SETUP;
                    end
                end
            end
            P_MA_SETUP: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b1;
                    n_phase = P_MA_HIGH;
                end
            end
            P_MA_HIGH: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl = 1'b0;
                    if (r_bytes == 8'd0) begin
                        n_sda   = 1'b0;
                        n_phase = P_SP_A;
                    end else begin
                        n_bit   = '0;
                        n_sda   = 1'b1;
                        n_phase = P_RX_LOW;
                    end
                end
            end
            P_SP_A: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = P_SP_B;
                end
            end
            P_SP_B: begin
                n_tick = dly ? '0 : tick_inc;
                if (dly) begin
                    res_word.done_res = 1'b1;
                    res_word.failed   = (r_stage == S_FAIL);
                    n_phase = P_IDLE;
                end
            end
            default: begin
                n_tick  = '0;
                n_phase = P_IDLE;
            end
        endcase

        res_word.busy_res = (n_phase != P_IDLE);
    end

    assign o_res = res_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_IDLE;
            r_stage   <= S_DEV;
            r_tick    <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_bytes   <= '0;
            r_poll    <= '0;
            r_is_read <= 1'b0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_tick    <= n_tick;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_poll    <= n_poll;
            r_is_read <= n_is_read;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RST;
            r_ato  <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ato  <= i_cfg_data;
                default:         r_half <= r_half;
            endcase
        end
    end

    `I2CM_ASSERT_NEXT(a_start_cmd, i_clk, i_rst_n,
        i_accept && (r_phase == P_IDLE) && ((i_word.op == OP_WRITE) || (i_word.op == OP_READ)),
        (r_phase == P_ST_A) && r_scl && r_sda && (r_bytes == $past(i_word.byte_count)),
        "start command did not open a start condition")
    `I2CM_ASSERT_NEXT(a_req_take, i_clk, i_rst_n,
        i_accept && res_word.data_req,
        (r_phase == P_LOAD_TAKE),
        "data request not followed by byte take")
    `I2CM_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n,
        i_accept && res_word.done_res,
        (r_phase == P_IDLE) && r_scl && r_sda,
        "bus not released after stop")
    `I2CM_ASSERT_NOW(a_rd_phase, i_clk, i_rst_n,
        res_word.rd_valid,
        (r_phase == P_RX_HIGH) && (r_bit == 4'd7),
        "read byte flagged outside the eighth bit")

endmodule

>>> rtl/i2cm_out_reg.sv
// Result register between the sequencer and the output channel
module i2cm_out_reg
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    input  logic      i_ready,
    output logic      o_room,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_word <= i_word;
        end
    end

endmodule

>>> rtl/i2c_master_register_access_core.sv
// Top level of the I2C register access core
//
//  channel   direction  handshake           word
//  input     in         i_valid / o_ready   t_in_word  (one bus tick)
//  result    out        o_valid / i_ready   t_out_word (one per tick)
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One tick per clock while the result register has room; its result appears in the cycle after acceptance.
// The tick logic is one pass through the sequencer's next-state decode.
// A word is taken whenever the result register is empty or being emptied.
// Synchronous active-low reset: idle, bus released, config at defaults.
module i2c_master_register_access_core
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_word   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_word  o_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic      room;
    logic      accept;
    t_out_word res_word;

    assign o_ready = room;
    assign accept  = i_valid && room;

    i2cm_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (res_word)
    );

    i2cm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_word  (res_word),
        .i_ready (i_ready),
        .o_room  (room),
        .o_valid (o_valid),
        .o_word  (o_data)
    );

endmodule
